// ----- rtl/core/caf_pkg.sv -----
// Package for the 8-bit CPU ALU with flags: opcodes, DAA constants and stage payload types.
// Used by caf_decode, caf_execute, caf_writeback and cpu_alu_with_flags_core.
// No dependencies.
package caf_pkg;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_XOR   = 5'd5,
        OP_OR    = 5'd6,
        OP_CP    = 5'd7,
        OP_INC   = 5'd8,
        OP_DEC   = 5'd9,
        OP_RLC   = 5'd10,
        OP_RRC   = 5'd11,
        OP_RL    = 5'd12,
        OP_RR    = 5'd13,
        OP_SLA   = 5'd14,
        OP_SRA   = 5'd15,
        OP_SWAP  = 5'd16,
        OP_SRL   = 5'd17,
        OP_BIT   = 5'd18,
        OP_RES   = 5'd19,
        OP_SET   = 5'd20,
        OP_DAA   = 5'd21,
        OP_CPL   = 5'd22,
        OP_SCF   = 5'd23,
        OP_CCF   = 5'd24,
        OP_RLCA  = 5'd25,
        OP_RRCA  = 5'd26,
        OP_RLA   = 5'd27,
        OP_RRA   = 5'd28,
        OP_ADD16 = 5'd29,
        OP_ADDSP = 5'd30
    } op_t;

    localparam logic [7:0] DAA_LIMIT  = 8'h99;
    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [3:0] DIGIT_MAX  = 4'h9;

    // one input transaction
    typedef struct packed {
        logic [4:0]  operation;
        logic [15:0] first_value;
        logic [15:0] second_value;
        logic [2:0]  bit_select;
        logic        zero_in;
        logic        negative_in;
        logic        half_in;
        logic        carry_in;
    } alu_in_t;

    // one result transaction
    typedef struct packed {
        logic [15:0] result_value;
        logic        zero_out;
        logic        negative_out;
        logic        half_out;
        logic        carry_out;
    } alu_out_t;

    // decode -> execute
    typedef struct packed {
        op_t         op;
        logic [15:0] x;
        logic [15:0] y;
        logic        cin;
        logic        daa_carry;
        logic [15:0] w1;
        logic [7:0]  v;
        logic [2:0]  bs;
        logic        z;
        logic        n;
        logic        h;
        logic        c;
    } dec_t;

    // execute -> writeback
    typedef struct packed {
        logic [15:0] r;
        logic        setz;
        logic        z;
        logic        n;
        logic        h;
        logic        c;
    } exe_t;

endpackage

// ----- rtl/core/caf_decode.sv -----
// First pipeline stage: operation decode, adder operand selection and DAA correction.
// Depends on caf_pkg.
module caf_decode (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  caf_pkg::alu_in_t cmd,
    output logic             out_valid,
    output caf_pkg::dec_t    dec
);

    logic          valid_reg;
    caf_pkg::dec_t dec_reg;
    caf_pkg::dec_t dec_next;

    logic [7:0] a;
    logic [7:0] v;
    logic       hi_adj;
    logic       lo_adj;
    logic [7:0] corr;

    always_comb
    begin
        a = cmd.first_value[7:0];
        v = cmd.second_value[7:0];

        // after add: high test uses the raw byte, low nibble is unchanged by +0x60
        if (cmd.negative_in)
        begin
            hi_adj = cmd.carry_in;
            lo_adj = cmd.half_in;
        end
        else
        begin
            hi_adj = cmd.carry_in | (a > caf_pkg::DAA_LIMIT);
            lo_adj = cmd.half_in | (a[3:0] > caf_pkg::DIGIT_MAX);
        end
        corr = (hi_adj ? caf_pkg::DAA_HI_ADJ : 8'h00) | (lo_adj ? caf_pkg::DAA_LO_ADJ : 8'h00);

        dec_next.op        = caf_pkg::op_t'(cmd.operation);
        dec_next.x         = {8'h00, a};
        dec_next.y         = 16'h0000;
        dec_next.cin       = 1'b0;
        dec_next.daa_carry = hi_adj;
        dec_next.w1        = cmd.first_value;
        dec_next.v         = v;
        dec_next.bs        = cmd.bit_select;
        dec_next.z         = cmd.zero_in;
        dec_next.n         = cmd.negative_in;
        dec_next.h         = cmd.half_in;
        dec_next.c         = cmd.carry_in;

        // subtraction is a + ~b + 1 - borrow
        unique case (cmd.operation)
            caf_pkg::OP_ADD:
            begin
                dec_next.y = {8'h00, v};
            end
            caf_pkg::OP_ADC:
            begin
                dec_next.y   = {8'h00, v};
                dec_next.cin = cmd.carry_in;
            end
            caf_pkg::OP_SUB, caf_pkg::OP_CP:
            begin
                dec_next.y   = {8'h00, ~v};
                dec_next.cin = 1'b1;
            end
            caf_pkg::OP_SBC:
            begin
                dec_next.y   = {8'h00, ~v};
                dec_next.cin = ~cmd.carry_in;
            end
            caf_pkg::OP_INC:
            begin
                dec_next.cin = 1'b1;
            end
            caf_pkg::OP_DEC:
            begin
                dec_next.y = 16'h00FF;
            end
            caf_pkg::OP_DAA:
            begin
                if (cmd.negative_in)
                begin
                    dec_next.y   = {8'h00, ~corr};
                    dec_next.cin = 1'b1;
                end
                else
                begin
                    dec_next.y = {8'h00, corr};
                end
            end
            caf_pkg::OP_ADD16:
            begin
                dec_next.x = cmd.first_value;
                dec_next.y = cmd.second_value;
            end
            caf_pkg::OP_ADDSP:
            begin
                dec_next.x = cmd.first_value;
                dec_next.y = {{8{v[7]}}, v};
            end
            default:
            begin
                dec_next.y = 16'h0000;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        dec_reg <= dec_next;
    end

    assign out_valid = valid_reg;
    assign dec       = dec_reg;

endmodule

// ----- rtl/core/caf_execute.sv -----
// Second pipeline stage: nibble-sliced 16-bit adder, logic, shift and bit operations.
// Depends on caf_pkg.
module caf_execute (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  caf_pkg::dec_t dec,
    output logic          out_valid,
    output caf_pkg::exe_t exe
);

    logic          valid_reg;
    caf_pkg::exe_t exe_reg;
    caf_pkg::exe_t exe_next;

    logic [4:0]  s0;
    logic [4:0]  s1;
    logic [4:0]  s2;
    logic [4:0]  s3;
    logic [15:0] sum;
    logic [7:0]  a;
    logic [7:0]  v;
    logic [7:0]  mask;

    always_comb
    begin
        s0   = {1'b0, dec.x[3:0]} + {1'b0, dec.y[3:0]} + {4'h0, dec.cin};
        s1   = {1'b0, dec.x[7:4]} + {1'b0, dec.y[7:4]} + {4'h0, s0[4]};
        s2   = {1'b0, dec.x[11:8]} + {1'b0, dec.y[11:8]} + {4'h0, s1[4]};
        s3   = {1'b0, dec.x[15:12]} + {1'b0, dec.y[15:12]} + {4'h0, s2[4]};
        sum  = {s3[3:0], s2[3:0], s1[3:0], s0[3:0]};
        a    = dec.w1[7:0];
        v    = dec.v;
        mask = 8'h01 << dec.bs;

        exe_next.r    = {8'h00, a};
        exe_next.setz = 1'b1;
        exe_next.z    = dec.z;
        exe_next.n    = dec.n;
        exe_next.h    = dec.h;
        exe_next.c    = dec.c;

        unique case (dec.op)
            caf_pkg::OP_ADD, caf_pkg::OP_ADC:
            begin
                exe_next.r = {8'h00, sum[7:0]};
                exe_next.n = 1'b0;
                exe_next.h = s0[4];
                exe_next.c = s1[4];
            end
            caf_pkg::OP_SUB, caf_pkg::OP_SBC:
            begin
                exe_next.r = {8'h00, sum[7:0]};
                exe_next.n = 1'b1;
                exe_next.h = ~s0[4];
                exe_next.c = ~s1[4];
            end
            caf_pkg::OP_CP:
            begin
                exe_next.setz = 1'b0;
                exe_next.z    = (sum[7:0] == 8'h00);
                exe_next.n    = 1'b1;
                exe_next.h    = ~s0[4];
                exe_next.c    = ~s1[4];
            end
            caf_pkg::OP_AND:
            begin
                exe_next.r = {8'h00, a & v};
                exe_next.n = 1'b0;
                exe_next.h = 1'b1;
                exe_next.c = 1'b0;
            end
            caf_pkg::OP_XOR:
            begin
                exe_next.r = {8'h00, a ^ v};
                exe_next.n = 1'b0;
                exe_next.h = 1'b0;
                exe_next.c = 1'b0;
            end
            caf_pkg::OP_OR:
            begin
                exe_next.r = {8'h00, a | v};
                exe_next.n = 1'b0;
                exe_next.h = 1'b0;
                exe_next.c = 1'b0;
            end
            caf_pkg::OP_INC:
            begin
                exe_next.r = {8'h00, sum[7:0]};
                exe_next.n = 1'b0;
                exe_next.h = s0[4];
            end
            caf_pkg::OP_DEC:
            begin
                exe_next.r = {8'h00, sum[7:0]};
                exe_next.n = 1'b1;
                exe_next.h = ~s0[4];
            end
            caf_pkg::OP_RLC, caf_pkg::OP_RLCA:
            begin
                exe_next.r = {8'h00, a[6:0], a[7]};
                exe_next.n = 1'b0;
                exe_next.h = 1'b0;
                exe_next.c = a[7];
            end
            caf_pkg::OP_RRC, caf_pkg::OP_RRCA:
            begin
                exe_next.r = {8'h00, a[0], a[7:1]};
                exe_next.n = 1'b0;
                exe_next.h = 1'b0;
                exe_next.c = a[0];
            end
            caf_pkg::OP_RL, caf_pkg::OP_RLA:
            begin
                exe_next.r = {8'h00, a[6:0], dec.c};
                exe_next.n = 1'b0;
                exe_next.h = 1'b0;
                exe_next.c = a[7];
            end
            caf_pkg::OP_RR, caf_pkg::OP_RRA:
            begin
                exe_next.r = {8'h00, dec.c, a[7:1]};
                exe_next.n = 1'b0;
                exe_next.h = 1'b0;
                exe_next.c = a[0];
            end
            caf_pkg::OP_SLA:
            begin
                exe_next.r = {8'h00, a[6:0], 1'b0};
                exe_next.n = 1'b0;
                exe_next.h = 1'b0;
                exe_next.c = a[7];
            end
            caf_pkg::OP_SRA:
            begin
                exe_next.r = {8'h00, a[7], a[7:1]};
                exe_next.n = 1'b0;
                exe_next.h = 1'b0;
                exe_next.c = a[0];
            end
            caf_pkg::OP_SWAP:
            begin
                exe_next.r = {8'h00, a[3:0], a[7:4]};
                exe_next.n = 1'b0;
                exe_next.h = 1'b0;
                exe_next.c = 1'b0;
            end
            caf_pkg::OP_SRL:
            begin
                exe_next.r = {8'h00, 1'b0, a[7:1]};
                exe_next.n = 1'b0;
                exe_next.h = 1'b0;
                exe_next.c = a[0];
            end
            caf_pkg::OP_BIT:
            begin
                exe_next.setz = 1'b0;
                exe_next.z    = ~a[dec.bs];
                exe_next.n    = 1'b0;
                exe_next.h    = 1'b1;
            end
            caf_pkg::OP_RES:
            begin
                exe_next.r    = {8'h00, a & ~mask};
                exe_next.setz = 1'b0;
            end
            caf_pkg::OP_SET:
            begin
                exe_next.r    = {8'h00, a | mask};
                exe_next.setz = 1'b0;
            end
            caf_pkg::OP_DAA:
            begin
                exe_next.r = {8'h00, sum[7:0]};
                exe_next.h = 1'b0;
                exe_next.c = dec.n ? dec.c : dec.daa_carry;
            end
            caf_pkg::OP_CPL:
            begin
                exe_next.r    = {8'h00, ~a};
                exe_next.setz = 1'b0;
                exe_next.n    = 1'b1;
                exe_next.h    = 1'b1;
            end
            caf_pkg::OP_SCF:
            begin
                exe_next.setz = 1'b0;
                exe_next.n    = 1'b0;
                exe_next.h    = 1'b0;
                exe_next.c    = 1'b1;
            end
            caf_pkg::OP_CCF:
            begin
                exe_next.setz = 1'b0;
                exe_next.n    = 1'b0;
                exe_next.h    = 1'b0;
                exe_next.c    = ~dec.c;
            end
            caf_pkg::OP_ADD16:
            begin
                exe_next.r    = sum;
                exe_next.setz = 1'b0;
                exe_next.n    = 1'b0;
                exe_next.h    = s2[4];
                exe_next.c    = s3[4];
            end
            caf_pkg::OP_ADDSP:
            begin
                exe_next.r    = sum;
                exe_next.setz = 1'b0;
                exe_next.z    = 1'b0;
                exe_next.n    = 1'b0;
                exe_next.h    = s0[4];
                exe_next.c    = s1[4];
            end
            default:
            begin
                // unused code: value and flags pass through
                exe_next.r    = dec.w1;
                exe_next.setz = 1'b0;
            end
        endcase

        // accumulator rotates always clear zero
        if (dec.op == caf_pkg::OP_RLCA || dec.op == caf_pkg::OP_RRCA ||
            dec.op == caf_pkg::OP_RLA || dec.op == caf_pkg::OP_RRA)
        begin
            exe_next.setz = 1'b0;
            exe_next.z    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        exe_reg <= exe_next;
    end

    assign out_valid = valid_reg;
    assign exe       = exe_reg;

endmodule

// ----- rtl/core/caf_writeback.sv -----
// Third pipeline stage: zero flag from the 8-bit result and the registered result strobe.
// Depends on caf_pkg.
module caf_writeback (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  caf_pkg::exe_t    exe,
    output logic             done,
    output caf_pkg::alu_out_t rsp
);

    logic              done_reg;
    caf_pkg::alu_out_t rsp_reg;
    caf_pkg::alu_out_t rsp_next;

    always_comb
    begin
        rsp_next.result_value = exe.r;
        rsp_next.zero_out     = exe.setz ? (exe.r[7:0] == 8'h00) : exe.z;
        rsp_next.negative_out = exe.n;
        rsp_next.half_out     = exe.h;
        rsp_next.carry_out    = exe.c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ----- rtl/core/cpu_alu_with_flags_core.sv -----
// Top level of the 8-bit CPU ALU with flags: decode, execute and writeback stages.
// Depends on caf_pkg, caf_decode, caf_execute and caf_writeback.
//
//  channel   ports                 direction  transfer
//  command   start, busy, cmd      in         start && !busy at a rising edge
//  result    done, rsp             out        done high for one cycle, taken at its end
//
// Every command transaction passes through the decode, execute and writeback registers
// before its result appears; one transaction may enter each cycle.
// busy is held low: the pipeline never stalls and the result side cannot stall.
// rst_n clears the stage valid bits asynchronously; data registers are not reset.
module cpu_alu_with_flags_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  caf_pkg::alu_in_t  cmd,
    output logic              done,
    output caf_pkg::alu_out_t rsp
);

    logic          dec_valid;
    caf_pkg::dec_t dec;
    logic          exe_valid;
    caf_pkg::exe_t exe;
    logic          accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    caf_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .cmd       (cmd),
        .out_valid (dec_valid),
        .dec       (dec)
    );

    caf_execute u_execute (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .dec       (dec),
        .out_valid (exe_valid),
        .exe       (exe)
    );

    caf_writeback u_writeback (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (exe_valid),
        .exe      (exe),
        .done     (done),
        .rsp      (rsp)
    );

    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("command transaction did not complete in three cycles");

    a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 3))
        else $error("result strobe without a matching command transaction");

    a_byte_result : assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(cmd.operation, 3) <= caf_pkg::OP_RRA) |-> (rsp.result_value[15:8] == 8'h00))
        else $error("upper result byte nonzero on an 8-bit operation");

    a_rot_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(cmd.operation, 3) == caf_pkg::OP_RLCA ||
                  $past(cmd.operation, 3) == caf_pkg::OP_RRCA ||
                  $past(cmd.operation, 3) == caf_pkg::OP_RLA ||
                  $past(cmd.operation, 3) == caf_pkg::OP_RRA)) |-> !rsp.zero_out)
        else $error("accumulator rotate left zero flag set");

endmodule

// ----- bench/cpu_alu_with_flags_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for cpu_alu_with_flags_core: directed and random ALU commands, each
// result compared with a behavioral value/flag predictor. Depends on caf_pkg and the core RTL.
module cpu_alu_with_flags_core_tb;

    localparam int unsigned RANDOM_ITEMS = 500;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned MAX_REPORTS  = 10;

    // Tracks commands in flight and checks each result against the predicted one.
    class flag_alu_scoreboard;
        caf_pkg::alu_out_t predicted_q[$];
        caf_pkg::alu_in_t  command_q[$];
        int unsigned       commands_seen;
        int unsigned       results_checked;
        int unsigned       mismatch_count;
        logic [31:0]       ops_seen;

        function new();
            commands_seen   = 0;
            results_checked = 0;
            mismatch_count  = 0;
            ops_seen        = '0;
        endfunction

        function caf_pkg::alu_out_t compute_alu_result(caf_pkg::alu_in_t c);
            caf_pkg::alu_out_t res;
            logic [7:0]  a;
            logic [7:0]  v;
            logic [7:0]  d;
            logic [15:0] r;
            logic [8:0]  sum9;
            logic [4:0]  lo5;
            logic [12:0] lo13;
            logic [16:0] sum17;
            logic        z;
            logic        n;
            logic        h;
            logic        cy;
            logic        t;
            logic        setz;

            a    = c.first_value[7:0];
            v    = c.second_value[7:0];
            r    = {8'h00, a};
            z    = c.zero_in;
            n    = c.negative_in;
            h    = c.half_in;
            cy   = c.carry_in;
            setz = 1'b1;

            case (c.operation)
                caf_pkg::OP_ADD, caf_pkg::OP_ADC:
                begin
                    t    = (c.operation == caf_pkg::OP_ADC) ? cy : 1'b0;
                    lo5  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, t};
                    sum9 = {1'b0, a} + {1'b0, v} + {8'd0, t};
                    h    = lo5[4];
                    cy   = sum9[8];
                    r    = {8'h00, sum9[7:0]};
                    n    = 1'b0;
                end
                caf_pkg::OP_SUB, caf_pkg::OP_SBC, caf_pkg::OP_CP:
                begin
                    // borrow out of a 5-bit / 9-bit difference gives half and carry
                    t    = (c.operation == caf_pkg::OP_SBC) ? cy : 1'b0;
                    lo5  = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, t};
                    sum9 = {1'b0, a} - {1'b0, v} - {8'd0, t};
                    h    = lo5[4];
                    cy   = sum9[8];
                    n    = 1'b1;
                    if (c.operation == caf_pkg::OP_CP)
                    begin
                        z    = (sum9[7:0] == 8'h00);
                        setz = 1'b0;
                    end
                    else
                    begin
                        r = {8'h00, sum9[7:0]};
                    end
                end
                caf_pkg::OP_AND:
                begin
                    r = {8'h00, a & v}; n = 1'b0; h = 1'b1; cy = 1'b0;
                end
                caf_pkg::OP_XOR:
                begin
                    r = {8'h00, a ^ v}; n = 1'b0; h = 1'b0; cy = 1'b0;
                end
                caf_pkg::OP_OR:
                begin
                    r = {8'h00, a | v}; n = 1'b0; h = 1'b0; cy = 1'b0;
                end
                caf_pkg::OP_INC:
                begin
                    r = {8'h00, a + 8'd1}; n = 1'b0; h = (a[3:0] == 4'hF);
                end
                caf_pkg::OP_DEC:
                begin
                    r = {8'h00, a - 8'd1}; n = 1'b1; h = (a[3:0] == 4'h0);
                end
                caf_pkg::OP_RLC, caf_pkg::OP_RLCA:
                begin
                    cy = a[7]; r = {8'h00, a[6:0], a[7]}; n = 1'b0; h = 1'b0;
                end
                caf_pkg::OP_RRC, caf_pkg::OP_RRCA:
                begin
                    cy = a[0]; r = {8'h00, a[0], a[7:1]}; n = 1'b0; h = 1'b0;
                end
                caf_pkg::OP_RL, caf_pkg::OP_RLA:
                begin
                    r = {8'h00, a[6:0], cy}; cy = a[7]; n = 1'b0; h = 1'b0;
                end
                caf_pkg::OP_RR, caf_pkg::OP_RRA:
                begin
                    r = {8'h00, cy, a[7:1]}; cy = a[0]; n = 1'b0; h = 1'b0;
                end
                caf_pkg::OP_SLA:
                begin
                    cy = a[7]; r = {8'h00, a[6:0], 1'b0}; n = 1'b0; h = 1'b0;
                end
                caf_pkg::OP_SRA:
                begin
                    cy = a[0]; r = {8'h00, a[7], a[7:1]}; n = 1'b0; h = 1'b0;
                end
                caf_pkg::OP_SWAP:
                begin
                    r = {8'h00, a[3:0], a[7:4]}; n = 1'b0; h = 1'b0; cy = 1'b0;
                end
                caf_pkg::OP_SRL:
                begin
                    cy = a[0]; r = {8'h00, 1'b0, a[7:1]}; n = 1'b0; h = 1'b0;
                end
                caf_pkg::OP_BIT:
                begin
                    z = ~a[c.bit_select]; n = 1'b0; h = 1'b1; setz = 1'b0;
                end
                caf_pkg::OP_RES:
                begin
                    d = a; d[c.bit_select] = 1'b0; r = {8'h00, d}; setz = 1'b0;
                end
                caf_pkg::OP_SET:
                begin
                    d = a; d[c.bit_select] = 1'b1; r = {8'h00, d}; setz = 1'b0;
                end
                caf_pkg::OP_DAA:
                begin
                    d = a;
                    if (!n)
                    begin
                        if (cy || d > 8'h99)
                        begin
                            d  = d + 8'h60;
                            cy = 1'b1;
                        end
                        if (h || d[3:0] > 4'h9)
                            d = d + 8'h06;
                    end
                    else
                    begin
                        if (cy)
                            d = d - 8'h60;
                        if (h)
                            d = d - 8'h06;
                    end
                    r = {8'h00, d};
                    h = 1'b0;
                end
                caf_pkg::OP_CPL:
                begin
                    r = {8'h00, ~a}; n = 1'b1; h = 1'b1; setz = 1'b0;
                end
                caf_pkg::OP_SCF:
                begin
                    cy = 1'b1; n = 1'b0; h = 1'b0; setz = 1'b0;
                end
                caf_pkg::OP_CCF:
                begin
                    cy = ~cy; n = 1'b0; h = 1'b0; setz = 1'b0;
                end
                caf_pkg::OP_ADD16:
                begin
                    lo13  = {1'b0, c.first_value[11:0]} + {1'b0, c.second_value[11:0]};
                    sum17 = {1'b0, c.first_value} + {1'b0, c.second_value};
                    h     = lo13[12];
                    cy    = sum17[16];
                    r     = sum17[15:0];
                    n     = 1'b0;
                    setz  = 1'b0;
                end
                caf_pkg::OP_ADDSP:
                begin
                    // flags come from the unsigned low-byte add
                    lo5  = {1'b0, c.first_value[3:0]} + {1'b0, v[3:0]};
                    sum9 = {1'b0, c.first_value[7:0]} + {1'b0, v};
                    h    = lo5[4];
                    cy   = sum9[8];
                    r    = c.first_value + {{8{v[7]}}, v};
                    n    = 1'b0;
                    z    = 1'b0;
                    setz = 1'b0;
                end
                default:
                begin
                    r    = c.first_value;
                    setz = 1'b0;
                end
            endcase

            if (setz)
                z = (r == 16'h0000);
            if (c.operation inside {caf_pkg::OP_RLCA, caf_pkg::OP_RRCA,
                                    caf_pkg::OP_RLA, caf_pkg::OP_RRA})
                z = 1'b0;

            res.result_value = r;
            res.zero_out     = z;
            res.negative_out = n;
            res.half_out     = h;
            res.carry_out    = cy;
            return res;
        endfunction

        function void note_command(caf_pkg::alu_in_t c);
            predicted_q.push_back(compute_alu_result(c));
            command_q.push_back(c);
            ops_seen[c.operation] = 1'b1;
            commands_seen++;
        endfunction

        function void check_result(caf_pkg::alu_out_t got);
            caf_pkg::alu_out_t exp_r;
            caf_pkg::alu_in_t  c;

            if (predicted_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with no command in flight: value=%h z%b n%b h%b c%b",
                             $realtime, got.result_value, got.zero_out, got.negative_out,
                             got.half_out, got.carry_out);
                return;
            end
            exp_r = predicted_q.pop_front();
            c     = command_q.pop_front();
            results_checked++;
            if (got.result_value !== exp_r.result_value || got.zero_out !== exp_r.zero_out ||
                got.negative_out !== exp_r.negative_out || got.half_out !== exp_r.half_out ||
                got.carry_out !== exp_r.carry_out)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $write("%0t: op %0d a=%h b=%h bit=%0d znhc=%b%b%b%b: ",
                           $realtime, c.operation, c.first_value, c.second_value,
                           c.bit_select, c.zero_in, c.negative_in, c.half_in, c.carry_in);
                    $display("exp %h znhc=%b%b%b%b, got %h znhc=%b%b%b%b",
                             exp_r.result_value, exp_r.zero_out, exp_r.negative_out,
                             exp_r.half_out, exp_r.carry_out,
                             got.result_value, got.zero_out, got.negative_out,
                             got.half_out, got.carry_out);
                end
            end
        endfunction

        function int unsigned outstanding();
            return predicted_q.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    caf_pkg::alu_in_t  cmd;
    logic              done;
    caf_pkg::alu_out_t rsp;

    flag_alu_scoreboard sb;

    cpu_alu_with_flags_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // transaction monitors: all bench drives after the time-zero setup are nonblocking, so these see pre-edge values
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_command(cmd);
        if (rst_n && done)
            sb.check_result(rsp);
    end

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h00FF;
            3:       return 16'h0FFF;
            4:       return 16'h0080;
            5:       return {8'($urandom), 8'h0F};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_bcd();
        return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    endfunction

    function automatic caf_pkg::alu_in_t random_command();
        caf_pkg::alu_in_t c;
        c.operation    = 5'($urandom_range(0, 31));
        c.first_value  = pick_word();
        c.second_value = pick_word();
        c.bit_select   = 3'($urandom_range(0, 7));
        c.zero_in      = 1'($urandom);
        c.negative_in  = 1'($urandom);
        c.half_in      = 1'($urandom);
        c.carry_in     = 1'($urandom);
        return c;
    endfunction

    // holds start until the transaction is taken
    task automatic issue(caf_pkg::alu_in_t c);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic pause(int unsigned cycles);
        start <= 1'b0;
        cmd   <= random_command();
        repeat (cycles) @(posedge clk);
    endtask

    // BCD add or subtract followed by the decimal adjust of its result and flags
    task automatic issue_bcd_pair();
        caf_pkg::alu_in_t  c;
        caf_pkg::alu_out_t r;
        c              = random_command();
        c.operation    = 5'($urandom_range(caf_pkg::OP_ADD, caf_pkg::OP_SBC));
        c.first_value  = {8'($urandom), pick_bcd()};
        c.second_value = {8'($urandom), pick_bcd()};
        r              = sb.compute_alu_result(c);
        issue(c);
        c.operation    = caf_pkg::OP_DAA;
        c.first_value  = {8'($urandom), r.result_value[7:0]};
        c.zero_in      = r.zero_out;
        c.negative_in  = r.negative_out;
        c.half_in      = r.half_out;
        c.carry_in     = r.carry_out;
        issue(c);
    endtask

    initial
    begin
        caf_pkg::alu_in_t c;
        int unsigned      sent;
        int unsigned      burst;

        sb    = new();
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        sent  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every opcode once, alternating all-ones and all-zero operands and flags
        for (int op = 0; op < 32; op++)
        begin
            c             = op[0] ? '0 : '1;
            c.operation   = 5'(op);
            issue(c);
        end
        // half and carry edges of the wide adds, sign of the stack offset, BCD overflow
        c = '0;
        c.operation = caf_pkg::OP_ADD16; c.first_value = 16'h0FFF; c.second_value = 16'h0001;
        issue(c);
        c.operation = caf_pkg::OP_ADDSP; c.first_value = 16'h00FF; c.second_value = 16'hFF80;
        issue(c);
        c.operation = caf_pkg::OP_SUB; c.first_value = 16'h0010; c.second_value = 16'h0001;
        issue(c);
        c.operation = caf_pkg::OP_DAA; c.first_value = 16'h009A; c.second_value = 16'h0000;
        issue(c);
        c.operation = caf_pkg::OP_DAA; c.first_value = 16'h0000; c.negative_in = 1'b1;
        c.half_in = 1'b1; c.carry_in = 1'b1;
        issue(c);
        pause($urandom_range(1, 5));

        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 16);
            repeat (burst)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    issue_bcd_pair();
                    sent += 2;
                end
                else
                begin
                    issue(random_command());
                    sent++;
                end
            end
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 6));
        end
        start <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d commands over %0d of 32 opcodes (%0d random), %0d results checked",
                 sb.commands_seen, $countones(sb.ops_seen), sent, sb.results_checked);
        $display("%0d mismatches, %0d results still outstanding",
                 sb.mismatch_count, sb.outstanding());
        if (sb.mismatch_count == 0 && sb.outstanding() == 0)
            $display("cpu_alu_with_flags_core_tb: PASS");
        else
            $display("cpu_alu_with_flags_core_tb: FAIL");
        $finish;
    end

    // ends the run if neither a command nor a result moves for too long
    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout after %0d idle cycles", STALL_LIMIT);
        $display("cpu_alu_with_flags_core_tb: FAIL");
        $finish;
    end

endmodule

// ----- cpu_alu_with_flags_core.f -----
rtl/core/caf_pkg.sv
rtl/core/caf_decode.sv
rtl/core/caf_execute.sv
rtl/core/caf_writeback.sv
rtl/core/cpu_alu_with_flags_core.sv
bench/cpu_alu_with_flags_core_tb.sv
